// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands. Each expects clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("invariant violated");

// Consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("next-cycle check failed");

`endif

// ----- rtl/mah_pkg.sv -----
// ----------------------------------------------------------------------------
// mah_pkg
// Shared constants, types and decimal digit helpers for the moving average
// level block.
// ----------------------------------------------------------------------------
package mah_pkg;

  // Configuration register map
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 10;
  localparam logic [CFG_IDX_W-1:0] REG_SET_VALUE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BAND      = 2'd1;
  localparam logic [CFG_W-1:0]     SET_RESET     = 10'd18;
  localparam logic [CFG_W-1:0]     BAND_RESET    = 10'd1;

  // Result field widths
  localparam int AVG_W = 10;
  localparam int DIG_W = 4;

  // Mean fits in 16 bits at the widest sample; one guard bit for compares
  localparam int WIDE_W = 17;
  // Remainder below 10000
  localparam int REM_W  = 14;

  localparam logic [REM_W-1:0] UNIT_THOUSANDS = 14'd1000;
  localparam logic [REM_W-1:0] UNIT_HUNDREDS  = 14'd100;
  localparam logic [REM_W-1:0] UNIT_TENS      = 14'd10;

  typedef struct packed {
    logic [DIG_W-1:0] q;
    logic [REM_W-1:0] r;
  } dig_t;

  // Value mod 10000 for values below 80000: three restoring steps
  function automatic logic [REM_W-1:0] mod_10k(input logic [WIDE_W-1:0] x);
    logic [WIDE_W-1:0] acc;
    acc = x;
    if (acc >= 17'd40000) acc = acc - 17'd40000;
    if (acc >= 17'd20000) acc = acc - 17'd20000;
    if (acc >= 17'd10000) acc = acc - 17'd10000;
    return acc[REM_W-1:0];
  endfunction

  // One decimal digit: x / unit and x % unit for x below 16 * unit
  function automatic dig_t dig_step(input logic [REM_W-1:0] x,
                                    input logic [REM_W-1:0] unit);
    logic [WIDE_W-1:0] acc;
    logic [WIDE_W-1:0] trial;
    dig_t              res;
    acc   = WIDE_W'(x);
    res.q = '0;
    for (int b = DIG_W - 1; b >= 0; b--) begin
      trial = WIDE_W'(unit) << b;
      if (acc >= trial) begin
        acc      = acc - trial;
        res.q[b] = 1'b1;
      end
    end
    res.r = acc[REM_W-1:0];
    return res;
  endfunction

endpackage

// ----- rtl/moving_average_hysteresis_level.sv -----
// Flow: an accepted sample word passes stage registers v1_r to v6_r in order
// and leaves as a result word. Throughput: one sample per cycle unless out_stall
// holds it; window RAM read/write and running total update run once per sample.
// Reset: synchronous; window reads as zero, total, pointer and level cleared,
// set_value = 18, band = 1. No clearing pass; samples are taken at once.
// ----------------------------------------------------------------------------
// moving_average_hysteresis_level
// Running window mean with decimal digits and a hysteresis level output.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module moving_average_hysteresis_level #(
  parameter int WINDOW_DEPTH = 20,
  parameter int SAMPLE_BITS  = 10
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // configuration
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [mah_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mah_pkg::CFG_W-1:0]      cfg_data,
  // sample channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [SAMPLE_BITS-1:0]         in_sample,
  // result channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [mah_pkg::AVG_W-1:0]      out_average,
  output logic                           out_level_on,
  output logic                           out_digit_thousands,
  output logic [mah_pkg::DIG_W-1:0]      out_digit_hundreds,
  output logic [mah_pkg::DIG_W-1:0]      out_digit_tens,
  output logic [mah_pkg::DIG_W-1:0]      out_digit_ones
);

  localparam int PW     = $clog2(WINDOW_DEPTH);
  localparam int TW     = SAMPLE_BITS + PW;
  // total / WINDOW_DEPTH as (total * RECIP) >> SH, exact for total < 2**TW
  localparam int SH     = TW + PW;
  localparam int MUL_W  = SH + 1;
  localparam int PROD_W = TW + MUL_W;
  localparam logic [MUL_W-1:0] RECIP =
    MUL_W'((64'd1 << SH) / 64'(WINDOW_DEPTH) + 64'd1);
  localparam logic [TW-1:0] TOTAL_MAX =
    TW'(WINDOW_DEPTH * ((1 << SAMPLE_BITS) - 1));
  localparam logic [PW:0] DEPTH_LAST = (PW+1)'(WINDOW_DEPTH - 1);

  // Configuration registers
  logic [mah_pkg::CFG_W-1:0] set_r;
  logic [mah_pkg::CFG_W-1:0] band_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      set_r  <= mah_pkg::SET_RESET;
      band_r <= mah_pkg::BAND_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        mah_pkg::REG_SET_VALUE: set_r  <= cfg_data;
        mah_pkg::REG_BAND:      band_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Pipeline stage valids and ready chain
  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r;
  logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;
  logic accept;

  assign rdy6     = !v6_r || !out_stall;
  assign rdy5     = !v5_r || rdy6;
  assign rdy4     = !v4_r || rdy5;
  assign rdy3     = !v3_r || rdy4;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_stall = !rdy1;
  assign accept   = in_valid && rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
      if (rdy5) v5_r <= v4_r;
      if (rdy6) v6_r <= v5_r;
    end
  end

  // Write pointer: oldest entry
  logic [PW-1:0] wp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
    end else if (accept) begin
      wp_r <= ({1'b0, wp_r} == DEPTH_LAST) ? '0 : wp_r + 1'b1;
    end
  end

  // Stage 1: oldest entry read from RAM; write back and total update on exit.
  // The next word reads the following entry, so a read never meets the
  // pending write of the same entry.
  logic [SAMPLE_BITS-1:0] smp1_r;
  logic [PW-1:0]          pos1_r;
  logic [SAMPLE_BITS-1:0] old1;
  logic                   mv1;
  logic [TW-1:0]          total_r;
  logic [TW-1:0]          total_nxt;

  always_ff @(posedge clk) begin
    if (accept) begin
      smp1_r <= in_sample;
      pos1_r <= wp_r;
    end
  end

  mah_window #(
    .DEPTH (WINDOW_DEPTH),
    .BITS  (SAMPLE_BITS)
  ) u_window (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (accept),
    .rd_addr (wp_r),
    .rd_data (old1),
    .wr_en   (mv1),
    .wr_addr (pos1_r),
    .wr_data (smp1_r)
  );

  assign mv1       = v1_r && rdy2;
  assign total_nxt = total_r - TW'(old1) + TW'(smp1_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= '0;
    end else if (mv1) begin
      total_r <= total_nxt;
    end
  end

  // Stage 2: reciprocal multiply
  logic [TW-1:0] tot2_r;

  always_ff @(posedge clk) begin
    if (mv1) begin
      tot2_r <= total_nxt;
    end
  end

  logic [PROD_W-1:0] prod3_r;

  always_ff @(posedge clk) begin
    if (v2_r && rdy3) begin
      prod3_r <= PROD_W'(tot2_r) * PROD_W'(RECIP);
    end
  end

  // Stage 3: mean, hysteresis, mod 10000
  logic [SAMPLE_BITS-1:0]     avg3;
  logic [mah_pkg::WIDE_W-1:0] avg_wide;
  logic [mah_pkg::WIDE_W-1:0] upper;
  logic [mah_pkg::WIDE_W-1:0] lower;
  logic                       level_r;
  logic                       level_nxt;
  logic                       mv3;

  assign avg3     = prod3_r[SH +: SAMPLE_BITS];
  assign avg_wide = mah_pkg::WIDE_W'(avg3);
  assign upper    = mah_pkg::WIDE_W'(set_r) + mah_pkg::WIDE_W'(band_r);
  // lower threshold saturates at zero
  assign lower    = (set_r > band_r) ? mah_pkg::WIDE_W'(set_r - band_r) : '0;
  assign mv3      = v3_r && rdy4;

  always_comb begin
    level_nxt = level_r;
    if (avg_wide > upper) begin
      level_nxt = 1'b1;
    end else if (avg_wide < lower) begin
      level_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r <= 1'b0;
    end else if (mv3) begin
      level_r <= level_nxt;
    end
  end

  logic [mah_pkg::AVG_W-1:0] avg4_r;
  logic                      lvl4_r;
  logic [mah_pkg::REM_W-1:0] rem4_r;

  always_ff @(posedge clk) begin
    if (mv3) begin
      avg4_r <= mah_pkg::AVG_W'(avg3);
      lvl4_r <= level_nxt;
      rem4_r <= mah_pkg::mod_10k(avg_wide);
    end
  end

  // Stage 4: thousands and hundreds digits
  mah_pkg::dig_t d_th;
  mah_pkg::dig_t d_hu;

  assign d_th = mah_pkg::dig_step(rem4_r, mah_pkg::UNIT_THOUSANDS);
  assign d_hu = mah_pkg::dig_step(d_th.r, mah_pkg::UNIT_HUNDREDS);

  logic [mah_pkg::AVG_W-1:0] avg5_r;
  logic                      lvl5_r;
  logic                      th5_r;
  logic [mah_pkg::DIG_W-1:0] hu5_r;
  logic [mah_pkg::REM_W-1:0] rem5_r;

  always_ff @(posedge clk) begin
    if (v4_r && rdy5) begin
      avg5_r <= avg4_r;
      lvl5_r <= lvl4_r;
      th5_r  <= d_th.q[0];
      hu5_r  <= d_hu.q;
      rem5_r <= d_hu.r;
    end
  end

  // Stage 5: tens and ones into the output register
  mah_pkg::dig_t d_te;

  assign d_te = mah_pkg::dig_step(rem5_r, mah_pkg::UNIT_TENS);

  logic [mah_pkg::AVG_W-1:0] avg6_r;
  logic                      lvl6_r;
  logic                      th6_r;
  logic [mah_pkg::DIG_W-1:0] hu6_r;
  logic [mah_pkg::DIG_W-1:0] te6_r;
  logic [mah_pkg::DIG_W-1:0] on6_r;

  always_ff @(posedge clk) begin
    if (v5_r && rdy6) begin
      avg6_r <= avg5_r;
      lvl6_r <= lvl5_r;
      th6_r  <= th5_r;
      hu6_r  <= hu5_r;
      te6_r  <= d_te.q;
      on6_r  <= d_te.r[mah_pkg::DIG_W-1:0];
    end
  end

  assign out_valid           = v6_r;
  assign out_average         = avg6_r;
  assign out_level_on        = lvl6_r;
  assign out_digit_thousands = th6_r;
  assign out_digit_hundreds  = hu6_r;
  assign out_digit_tens      = te6_r;
  assign out_digit_ones      = on6_r;

  // Checks
  `ASSERT_ALWAYS(a_wp_range, {1'b0, wp_r} <= DEPTH_LAST)
  `ASSERT_ALWAYS(a_total_bound, total_r <= TOTAL_MAX)
  `ASSERT_NEXT(a_level_on, mv3 && (avg_wide > upper), level_r)
  `ASSERT_NEXT(a_level_off, mv3 && (avg_wide < lower) && !(avg_wide > upper), !level_r)

endmodule

// ----- rtl/mah_window.sv -----
// ----------------------------------------------------------------------------
// mah_window
// Sample window RAM: one write and one registered read per cycle. Entries
// never written since reset read back as zero.
// ----------------------------------------------------------------------------
module mah_window #(
  parameter int DEPTH = 20,
  parameter int BITS  = 10
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [BITS-1:0]          rd_data,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [BITS-1:0]          wr_data
);

  logic [BITS-1:0]  mem [DEPTH];
  logic [BITS-1:0]  rd_q_r;
  logic             rd_vld_r;
  logic [DEPTH-1:0] vld_r;

  // Storage array and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q_r <= mem[rd_addr];
    end
  end

  // Written flags, cleared by reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= vld_r[rd_addr];
      end
    end
  end

  assign rd_data = rd_vld_r ? rd_q_r : '0;

endmodule

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for moving_average_hysteresis_level. Samples go in
// through a sender that is bursty in most phases, results come out through a receiver that stalls
// on its own pattern. A scoreboard keeps its own window, running total and
// level state, predicts every result word and checks it as a whole word.
// The register settings are swept between phases while the block is idle.
// ----------------------------------------------------------------------------
module testbench;

  localparam int WIN_DEPTH    = 20;
  localparam int SAMPLE_W     = 10;
  localparam int SAMPLE_MAX   = (1 << SAMPLE_W) - 1;
  localparam int CFG_MAX      = (1 << mah_pkg::CFG_W) - 1;
  localparam int DRAIN_CYCLES = 12;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int PHASE_ITEMS  = 85;
  localparam int NUM_PHASES   = 8;
  localparam int REPORT_MAX   = 10;

  typedef struct packed {
    logic [mah_pkg::AVG_W-1:0] average;
    logic                      level_on;
    logic                      thousands;
    logic [mah_pkg::DIG_W-1:0] hundreds;
    logic [mah_pkg::DIG_W-1:0] tens;
    logic [mah_pkg::DIG_W-1:0] ones;
  } level_word_t;

  typedef enum logic [1:0] {
    STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_RUNS
  } stall_mode_t;

  // --------------------------------------------------------------------------
  // Scoreboard: window mean, decimal split and hysteresis level
  // --------------------------------------------------------------------------
  class level_scoreboard;
    logic [SAMPLE_W-1:0]       window_q [WIN_DEPTH];
    int unsigned               wr_pos;
    int unsigned               total;
    bit                        level;
    logic [mah_pkg::CFG_W-1:0] set_val;
    logic [mah_pkg::CFG_W-1:0] band_val;
    level_word_t               expected_q [$];
    int unsigned               mismatches;
    int unsigned               samples_seen;
    int unsigned               words_checked;
    int unsigned               level_flips;

    function new();
      foreach (window_q[i]) window_q[i] = '0;
      wr_pos        = 0;
      total         = 0;
      level         = 1'b0;
      set_val       = mah_pkg::SET_RESET;
      band_val      = mah_pkg::BAND_RESET;
      mismatches    = 0;
      samples_seen  = 0;
      words_checked = 0;
      level_flips   = 0;
    endfunction

    function void write_reg(logic [mah_pkg::CFG_IDX_W-1:0] idx,
                            logic [mah_pkg::CFG_W-1:0] data);
      case (idx)
        mah_pkg::REG_SET_VALUE: set_val  = data;
        mah_pkg::REG_BAND:      band_val = data;
        default:                ;
      endcase
    endfunction

    // Accepted sample: update the window and queue the predicted word
    function void note_sample(logic [SAMPLE_W-1:0] s);
      level_word_t w;
      int unsigned avg, upper, lower, rest;
      bit          prev;
      prev  = level;
      total = total - window_q[wr_pos] + s;
      window_q[wr_pos] = s;
      wr_pos = (wr_pos + 1 >= WIN_DEPTH) ? 0 : wr_pos + 1;
      avg   = total / WIN_DEPTH;
      upper = set_val + band_val;
      lower = (set_val > band_val) ? set_val - band_val : 0;
      if (avg > upper) level = 1'b1;
      else if (avg < lower) level = 1'b0;
      if (level != prev) level_flips++;
      rest        = avg % 10000;
      w.average   = avg[mah_pkg::AVG_W-1:0];
      w.level_on  = level;
      w.thousands = 1'((rest / 1000) & 1);
      rest        = rest % 1000;
      w.hundreds  = mah_pkg::DIG_W'(rest / 100);
      rest        = rest % 100;
      w.tens      = mah_pkg::DIG_W'(rest / 10);
      w.ones      = mah_pkg::DIG_W'(rest % 10);
      expected_q.push_back(w);
      samples_seen++;
    endfunction

    // Result word leaving the block: compare with the oldest prediction
    function void check_result(level_word_t got);
      level_word_t exp_w;
      words_checked++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("ERROR: unexpected result word avg=%0d lvl=%0b",
                   got.average, got.level_on);
        return;
      end
      exp_w = expected_q.pop_front();
      if (got !== exp_w) begin
        mismatches++;
        if (mismatches <= REPORT_MAX) begin
          $display("ERROR: word %0d exp avg=%0d lvl=%0b dig=%0d%0d%0d%0d",
                   words_checked, exp_w.average, exp_w.level_on, exp_w.thousands,
                   exp_w.hundreds, exp_w.tens, exp_w.ones);
          $display("       word %0d got avg=%0d lvl=%0b dig=%0d%0d%0d%0d",
                   words_checked, got.average, got.level_on,
                   got.thousands, got.hundreds, got.tens, got.ones);
        end
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, DUT
  // --------------------------------------------------------------------------
  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [mah_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [mah_pkg::CFG_W-1:0]     cfg_data = '0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic [SAMPLE_W-1:0]           in_sample = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic [mah_pkg::AVG_W-1:0]     out_average;
  logic                          out_level_on;
  logic                          out_digit_thousands;
  logic [mah_pkg::DIG_W-1:0]     out_digit_hundreds;
  logic [mah_pkg::DIG_W-1:0]     out_digit_tens;
  logic [mah_pkg::DIG_W-1:0]     out_digit_ones;

  level_scoreboard sb;
  int unsigned     cycle_count = 0;
  int unsigned     settings_run = 0;
  stall_mode_t     stall_mode = STALL_NONE;
  int unsigned     stall_mode_left = 0;
  int unsigned     stall_run_left = 0;
  bit              stall_run_on = 1'b0;

  initial begin
    forever #2 clk = ~clk;
  end

  moving_average_hysteresis_level #(
    .WINDOW_DEPTH (WIN_DEPTH),
    .SAMPLE_BITS  (SAMPLE_W)
  ) u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_sample           (in_sample),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_average         (out_average),
    .out_level_on        (out_level_on),
    .out_digit_thousands (out_digit_thousands),
    .out_digit_hundreds  (out_digit_hundreds),
    .out_digit_tens      (out_digit_tens),
    .out_digit_ones      (out_digit_ones)
  );

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d words outstanding", cycle_count, sb.pending());
      $display("Regression FAIL");
      $finish;
    end
  end

  // Monitor: accepted samples first, then result words
  always @(posedge clk) begin
    if (rst_n && sb != null) begin
      if (in_valid && !in_stall) sb.note_sample(in_sample);
      if (out_valid && !out_stall)
        sb.check_result({out_average, out_level_on, out_digit_thousands,
                         out_digit_hundreds, out_digit_tens, out_digit_ones});
    end
  end

  // Receiver back-pressure in four random modes: none, light, heavy and runs
  always @(posedge clk) begin
    logic next_stall;
    if (stall_mode_left == 0) begin
      stall_mode      = stall_mode_t'($urandom_range(0, 3));
      stall_mode_left = $urandom_range(20, 120);
    end else begin
      stall_mode_left--;
    end
    case (stall_mode)
      STALL_LIGHT: next_stall = ($urandom_range(0, 3) == 0);
      STALL_HEAVY: next_stall = ($urandom_range(0, 3) != 0);
      STALL_RUNS: begin
        if (stall_run_left == 0) begin
          stall_run_on   = !stall_run_on;
          stall_run_left = stall_run_on ? $urandom_range(1, 12) : $urandom_range(1, 16);
        end else begin
          stall_run_left--;
        end
        next_stall = stall_run_on;
      end
      default: next_stall = 1'b0;
    endcase
    out_stall <= next_stall;
  end

  // --------------------------------------------------------------------------
  // Driver tasks
  // --------------------------------------------------------------------------
  // Leaves cfg_valid high; caller drops it after the last write
  task automatic cfg_write(input logic [mah_pkg::CFG_IDX_W-1:0] idx,
                           input logic [mah_pkg::CFG_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
  endtask

  // Leaves in_valid high so bursts run back to back
  task automatic push_sample(input logic [SAMPLE_W-1:0] s);
    in_valid  <= 1'b1;
    in_sample <= s;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    // let the monitor record the last accepted sample first
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Random samples steered around the current thresholds
  task automatic run_phase(input int n_items, input bit bursty);
    int target, jitter, lo_th, hi_th, burst_left, k, v;
    lo_th      = (sb.set_val > sb.band_val) ? int'(sb.set_val) - int'(sb.band_val) : 0;
    hi_th      = int'(sb.set_val) + int'(sb.band_val);
    target     = $urandom_range(0, SAMPLE_MAX);
    jitter     = 8;
    burst_left = $urandom_range(1, 40);
    for (k = 0; k < n_items; k++) begin
      // New target every 25 samples: near a threshold, right on it, at an extreme, or anywhere
      if (k % 25 == 0) begin
        jitter = 8;
        case ($urandom_range(0, 4))
          0: target = lo_th + int'($urandom_range(0, 6)) - 3;
          1: target = hi_th + int'($urandom_range(0, 6)) - 3;
          2: target = $urandom_range(0, SAMPLE_MAX);
          3: target = $urandom_range(0, 1) ? SAMPLE_MAX : 0;
          default: begin
            target = $urandom_range(0, 1) ? hi_th : lo_th;
            jitter = 0;
          end
        endcase
      end
      case ($urandom_range(0, 9))
        0: v = $urandom_range(0, SAMPLE_MAX);
        1: v = $urandom_range(0, 1) ? SAMPLE_MAX : 0;
        default: v = target + int'($urandom_range(0, 2 * jitter)) - jitter;
      endcase
      if (v < 0) v = 0;
      if (v > SAMPLE_MAX) v = SAMPLE_MAX;
      if (bursty && burst_left == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
        burst_left = $urandom_range(1, 40);
      end
      push_sample(SAMPLE_W'(v));
      if (burst_left != 0) burst_left--;
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int p, i;
    int set_list  [NUM_PHASES];
    int band_list [NUM_PHASES];
    sb = new();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part under reset settings: values 0, 1, 512 and 1000, then a full window at max
    push_sample('0);
    push_sample(SAMPLE_W'(1));
    push_sample(SAMPLE_W'(512));
    push_sample(SAMPLE_W'(1000));
    repeat (WIN_DEPTH) push_sample(SAMPLE_W'(SAMPLE_MAX));
    drain();
    settings_run++;

    // Register sweep: plain threshold at zero, both at max, set at max alone, a mid
    // band, lower threshold saturating at zero, plain threshold at 300, random settings
    set_list  = '{0, CFG_MAX, CFG_MAX, 512, 5, 300, 0, 0};
    band_list = '{0, CFG_MAX, 0, 100, 10, 0, CFG_MAX, 0};
    set_list[6]  = $urandom_range(0, CFG_MAX);
    set_list[7]  = $urandom_range(0, CFG_MAX);
    band_list[7] = $urandom_range(0, 64);

    for (p = 0; p < NUM_PHASES; p++) begin
      cfg_write(mah_pkg::REG_SET_VALUE, mah_pkg::CFG_W'(set_list[p]));
      cfg_write(mah_pkg::REG_BAND, mah_pkg::CFG_W'(band_list[p]));
      // unmapped indexes must leave both registers alone
      if (p == 2)
        for (i = int'(mah_pkg::REG_BAND) + 1; i < (1 << mah_pkg::CFG_IDX_W); i++)
          cfg_write(mah_pkg::CFG_IDX_W'(i), mah_pkg::CFG_W'($urandom_range(0, CFG_MAX)));
      cfg_valid <= 1'b0;
      @(posedge clk);
      run_phase(PHASE_ITEMS, (p % 3) != 1);
      drain();
      settings_run++;
    end

    $display("Run covered %0d samples and %0d result words over %0d register settings.",
             sb.samples_seen, sb.words_checked, settings_run);
    $display("Level output changed %0d times; %0d mismatches, %0d words outstanding.",
             sb.level_flips, sb.mismatches, sb.pending());
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- moving_average_hysteresis_level.f -----
+incdir+rtl
rtl/mah_pkg.sv
rtl/mah_window.sv
rtl/moving_average_hysteresis_level.sv
tb/testbench.sv
